>>> design/ple_pkg.sv
// Shared types and codes for the positional list engine.
// No dependencies; compile before every other file of the block.
`default_nettype none

package ple_pkg;

	// Operation codes carried on the request word.
	typedef enum logic [2:0] {
		MODE_INS_HEAD = 3'd0,
		MODE_INS_TAIL = 3'd1,
		MODE_INS_AT   = 3'd2,
		MODE_DEL_HEAD = 3'd3,
		MODE_DEL_TAIL = 3'd4,
		MODE_DEL_AT   = 3'd5,
		MODE_READ_AT  = 3'd6
	} mode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// Per-cycle command broadcast to every storage cell.
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2
	} cell_op_t;

	localparam int unsigned MODE_W   = 3;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned POS_W    = 5;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 5;

endpackage

`default_nettype wire

>>> design/ple_in_if.sv
// Request channel of the positional list engine: valid/ready plus one word.
// Stand-alone; field widths follow the request format.
`default_nettype none

interface ple_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [31:0] value;
	logic [4:0]  position;

	modport source (output valid, output mode, output value, output position, input ready);
	modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

`default_nettype wire

>>> design/ple_out_if.sv
// Response channel of the positional list engine: valid/ready plus one word.
// Stand-alone; field widths follow the response format.
`default_nettype none

interface ple_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [4:0]  element_count;
	logic [31:0] read_value;

	modport source (output valid, output status, output element_count, output read_value,
		input ready);
	modport sink   (input valid, input status, input element_count, input read_value,
		output ready);
endinterface

`default_nettype wire

>>> design/positional_list_engine.sv
// Positional list engine top level: request decode, element count, response skid.
// Depends on ple_pkg, ple_in_if, ple_out_if and ple_chain.
//
// Usage:
//   req carries one word per operation: mode, value and a 1-based position.
//   Modes insert at head, tail or a position, delete at head, tail or a
//   position, or read the element at a position. Every accepted word yields
//   exactly one rsp word with status (ok, invalid position, full, empty),
//   the element count after the operation and, for a successful read, the
//   element read (zero otherwise).
// Throughput:
//   The response is registered in the output slot, or in the skid while rsp stalls.
//   One word per cycle is sustained unless rsp stalls: all cells shift in parallel
//   from a broadcast index compare, so the list update finishes in the accept cycle.
// Stalls:
//   rsp has an output register plus a one-word skid register. While the
//   receiver stalls, one further request is still taken into the skid;
//   req.ready drops only once the skid is occupied.
// Reset:
//   arst_n clears the element count and both response slots at once; the
//   list is empty afterward and the element store needs no clearing pass.
`default_nettype none

module positional_list_engine #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ple_in_if.sink    req,
	ple_out_if.source rsp
);
	import ple_pkg::*;

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  element_count;
		logic [VALUE_W-1:0]  read_value;
	} rsp_word_t;

	// Element count and response slots.
	logic [CNT_W-1:0] cnt_q;
	logic             out_v_q;
	rsp_word_t        out_q;
	logic             skid_v_q;
	rsp_word_t        skid_q;

	// Decode results.
	status_t          st;
	cell_op_t         op_dec;
	cell_op_t         op;
	logic [CMP_W-1:0] idx_w;
	logic [CNT_W-1:0] cnt_next;
	logic             rd_hit;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic [CMP_W-1:0] pos_m1;
	logic             full;
	logic             empty;
	logic             accept;
	logic [DATA_WIDTH-1:0] rd_data;
	rsp_word_t        result;

	assign req.ready = !skid_v_q;
	assign accept    = req.valid && req.ready;

	assign pos_w  = CMP_W'(req.position);
	assign cnt_w  = CMP_W'(cnt_q);
	assign pos_m1 = pos_w - CMP_W'(1);
	assign full   = (cnt_q == CNT_FULL);
	assign empty  = (cnt_q == '0);

	// Check the request against the current count and pick the cell command.
	always_comb begin
		st       = ST_OK;
		op_dec   = CELL_HOLD;
		idx_w    = '0;
		cnt_next = cnt_q;
		rd_hit   = 1'b0;
		unique case (req.mode)
			MODE_INS_HEAD, MODE_INS_TAIL: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					op_dec   = CELL_INS;
					idx_w    = (req.mode == MODE_INS_HEAD) ? '0 : cnt_w;
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			MODE_INS_AT: begin
				if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
					st = ST_INVALID;
				end else if (full) begin
					st = ST_FULL;
				end else begin
					op_dec   = CELL_INS;
					idx_w    = pos_m1;
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			MODE_DEL_HEAD, MODE_DEL_TAIL: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					op_dec   = CELL_DEL;
					idx_w    = (req.mode == MODE_DEL_HEAD) ? '0 : cnt_w - CMP_W'(1);
					cnt_next = cnt_q - CNT_W'(1);
				end
			end
			MODE_DEL_AT: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (pos_w == '0 || pos_w > cnt_w) begin
					st = ST_INVALID;
				end else begin
					op_dec   = CELL_DEL;
					idx_w    = pos_m1;
					cnt_next = cnt_q - CNT_W'(1);
				end
			end
			MODE_READ_AT: begin
				if (pos_w == '0 || pos_w > cnt_w) begin
					st = ST_INVALID;
				end else begin
					rd_hit = 1'b1;
					idx_w  = pos_m1;
				end
			end
			default: begin
				st = ST_INVALID;
			end
		endcase
	end

	// Drive the cells only on an accepted word.
	assign op = accept ? op_dec : CELL_HOLD;

	ple_chain #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_chain (
		.clk      (clk),
		.op       (op),
		.idx      (IDX_W'(idx_w)),
		.new_data (DATA_WIDTH'(req.value)),
		.rd_idx   (IDX_W'(idx_w)),
		.rd_data  (rd_data)
	);

	assign result.status        = st;
	assign result.element_count = COUNT_W'(cnt_next);
	assign result.read_value    = rd_hit ? VALUE_W'(rd_data) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_next;
		end
	end

	// Output register plus skid: advance when the output slot frees, else park.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || rsp.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept;
			end
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || rsp.ready) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= result;
			end
		end else if (accept) begin
			skid_q <= result;
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.status        = out_q.status;
	assign rsp.element_count = out_q.element_count;
	assign rsp.read_value    = out_q.read_value;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("element count above capacity");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word held while output slot empty");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_dec == CELL_INS) |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && st != ST_OK) |=> cnt_q == $past(cnt_q))
		else $error("rejected word changed the list");
`endif

endmodule

`default_nettype wire

>>> design/ple_cell.sv
// One storage cell of the list: holds a single element and shifts with its neighbors.
// Depends on ple_pkg for the cell command type.
`default_nettype none

module ple_cell #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned INDEX      = 0
) (
	input  wire logic                       clk,
	input  wire ple_pkg::cell_op_t          op,
	input  wire logic [$clog2(DEPTH)-1:0]   idx,
	input  wire logic [DATA_WIDTH-1:0]      new_data,
	input  wire logic [DATA_WIDTH-1:0]      left_data,
	input  wire logic [DATA_WIDTH-1:0]      right_data,
	output logic      [DATA_WIDTH-1:0]      data
);
	import ple_pkg::*;

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;

	// Insert: take the new word at the slot, shift back behind it.
	// Delete: pull forward from the slot on.
	always_ff @(posedge clk) begin
		unique case (op)
			CELL_INS: begin
				if (MY_IDX == idx) begin
					data_q <= new_data;
				end else if (MY_IDX > idx) begin
					data_q <= left_data;
				end
			end
			CELL_DEL: begin
				if (MY_IDX >= idx) begin
					data_q <= right_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

`default_nettype wire

>>> design/ple_chain.sv
// Row of DEPTH list cells with neighbor links and the positional read select.
// Depends on ple_pkg and ple_cell.
`default_nettype none

module ple_chain #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                       clk,
	input  wire ple_pkg::cell_op_t          op,
	input  wire logic [$clog2(DEPTH)-1:0]   idx,
	input  wire logic [DATA_WIDTH-1:0]      new_data,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_idx,
	output logic      [DATA_WIDTH-1:0]      rd_data
);
	import ple_pkg::*;

	localparam int unsigned IDX_W = $clog2(DEPTH);

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		// Head has no left neighbor; tail refills from itself on a delete.
		if (i == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		ple_cell #(
			.DEPTH      (DEPTH),
			.DATA_WIDTH (DATA_WIDTH),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.idx        (idx),
			.new_data   (new_data),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i])
		);
	end

	// Each cell compares its own index; at most one matches.
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (IDX_W'(i) == rd_idx) begin
				rd_data = rd_data | cell_data[i];
			end
		end
	end

endmodule

`default_nettype wire

>>> test/tb_positional_list_engine.sv
// Self-checking testbench for positional_list_engine: drives request words with random gaps,
// stalls the response side at random and checks every response against a list predictor.
// Depends on ple_pkg, ple_in_if, ple_out_if and the engine RTL.
`timescale 1ns / 1ps

module tb_positional_list_engine;
	import ple_pkg::*;

	localparam int unsigned LIST_DEPTH = 16;
	localparam int unsigned RANDOM_WORDS = 1000;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 4;
	// The request field is three bits wide; the last code has no operation behind it.
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	typedef enum int unsigned {
		TREND_GROW,
		TREND_SHRINK,
		TREND_MIXED
	} trend_t;

	// One response word as the engine should return it.
	typedef struct packed {
		status_t     status;
		logic [4:0]  count;
		logic [31:0] value;
	} list_result_t;

	// Tracks the list contents and the queue of responses still owed by the engine.
	class list_scoreboard;
		logic [31:0]  cells [LIST_DEPTH];
		int unsigned  occupancy;
		list_result_t awaited [$];
		int unsigned  errors;

		function new();
			occupancy = 0;
			errors = 0;
		endfunction

		function void shift_in(int unsigned idx, logic [31:0] v);
			int unsigned k;
			for (k = occupancy; k > idx; k--)
				cells[k] = cells[k - 1];
			cells[idx] = v;
			occupancy++;
		endfunction

		function void take_out(int unsigned idx);
			int unsigned k;
			for (k = idx; k + 1 < occupancy; k++)
				cells[k] = cells[k + 1];
			occupancy--;
		endfunction

		// Apply one accepted request to the list and queue the response it owes.
		function void note_request(logic [2:0] mode, logic [31:0] value, logic [4:0] pos);
			list_result_t r;
			r.status = ST_OK;
			r.value = '0;
			case (mode)
				MODE_INS_HEAD, MODE_INS_TAIL: begin
					if (occupancy >= LIST_DEPTH)
						r.status = ST_FULL;
					else
						shift_in(mode == MODE_INS_HEAD ? 0 : occupancy, value);
				end
				MODE_INS_AT: begin
					if (pos < 1 || pos > occupancy + 1)
						r.status = ST_INVALID;
					else if (occupancy >= LIST_DEPTH)
						r.status = ST_FULL;
					else
						shift_in(pos - 1, value);
				end
				MODE_DEL_HEAD, MODE_DEL_TAIL: begin
					if (occupancy == 0)
						r.status = ST_EMPTY;
					else
						take_out(mode == MODE_DEL_HEAD ? 0 : occupancy - 1);
				end
				MODE_DEL_AT: begin
					if (occupancy == 0)
						r.status = ST_EMPTY;
					else if (pos < 1 || pos > occupancy)
						r.status = ST_INVALID;
					else
						take_out(pos - 1);
				end
				MODE_READ_AT: begin
					if (pos < 1 || pos > occupancy)
						r.status = ST_INVALID;
					else
						r.value = cells[pos - 1];
				end
				default: begin
					r.status = ST_INVALID;
				end
			endcase
			r.count = occupancy[4:0];
			awaited.push_back(r);
		endfunction

		task report(string what);
			$display("[%0t] error: %s", $time, what);
			errors++;
		endtask

		// Compare one accepted response with the oldest owed one.
		task check_response(logic [1:0] st, logic [4:0] cnt, logic [31:0] rv);
			list_result_t e;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected response status=%0d count=%0d value=%h",
					st, cnt, rv));
			end else begin
				e = awaited.pop_front();
				if (st !== e.status)
					report($sformatf("status %0d, wanted %0d", st, e.status));
				if (cnt !== e.count)
					report($sformatf("element_count %0d, wanted %0d", cnt, e.count));
				if (rv !== e.value)
					report($sformatf("read_value %h, wanted %h", rv, e.value));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ple_in_if  req_ch ();
	ple_out_if rsp_ch ();

	list_scoreboard sb = new();

	// Sender holds off only outside calm stretches.
	bit send_calm;

	positional_list_engine #(
		.DEPTH(LIST_DEPTH),
		.DATA_WIDTH(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Length of one idle stretch: mostly short, now and then long.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 93)
			return $urandom_range(4, 8);
		return $urandom_range(9, 24);
	endfunction

	// Present one request word and hold it until the engine takes it.
	// A zero gap keeps valid high straight into the next word.
	task automatic send_word(logic [2:0] mode, logic [31:0] value, logic [4:0] pos);
		int unsigned gap;
		gap = 0;
		if (!send_calm && $urandom_range(0, 2) == 0)
			gap = idle_len();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.mode     <= mode;
		req_ch.value    <= value;
		req_ch.position <= pos;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// Pick an operation leaning toward growing, shrinking or neither.
	function automatic logic [2:0] pick_mode(trend_t trend);
		mode_t       ins_modes [3];
		mode_t       del_modes [3];
		int unsigned ins_w;
		int unsigned del_w;
		int unsigned r;
		ins_modes = '{MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_AT};
		del_modes = '{MODE_DEL_HEAD, MODE_DEL_TAIL, MODE_DEL_AT};
		case (trend)
			TREND_GROW: begin
				ins_w = 75;
				del_w = 17;
			end
			TREND_SHRINK: begin
				ins_w = 25;
				del_w = 60;
			end
			default: begin
				ins_w = 40;
				del_w = 40;
			end
		endcase
		r = $urandom_range(0, 99);
		if (r < ins_w)
			return ins_modes[$urandom_range(0, 2)];
		else if (r < ins_w + del_w)
			return del_modes[$urandom_range(0, 2)];
		else if (r < 99)
			return MODE_READ_AT;
		return MODE_UNUSED;
	endfunction

	// Monitor: note each accepted request, check each accepted response.
	// Sampled at the edge, so both sides see the values from before it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.mode, req_ch.value, req_ch.position);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.status, rsp_ch.element_count, rsp_ch.read_value);
		end
	end

	// Watchdog: end the run if no word moves on either side for too long.
	always @(posedge clk) begin
		int unsigned idle_cycles;
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Receiver: stall in bursts, with calm stretches of steady ready every so often.
	initial begin
		int unsigned stall_left;
		int unsigned cycle;
		bit          calm;
		stall_left = 0;
		cycle = 0;
		calm = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle % 128 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (stall_left != 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left = idle_len() - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus: directed corner cases, then random phases, then drain.
	initial begin
		int unsigned sent;
		int unsigned span;
		int unsigned i;
		trend_t      trend;
		logic [2:0]  mode;
		logic [31:0] value;
		logic [4:0]  pos;

		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.mode     <= MODE_INS_HEAD;
		req_ch.value    <= '0;
		req_ch.position <= '0;
		send_calm = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: reads and deletes of every kind, out-of-range inserts.
		send_word(MODE_READ_AT, 32'h0, 5'd1);
		send_word(MODE_DEL_HEAD, 32'h0, 5'd0);
		send_word(MODE_DEL_TAIL, 32'hFFFF_FFFF, 5'd31);
		send_word(MODE_DEL_AT, 32'h0, 5'd1);
		send_word(MODE_DEL_AT, 32'h0, 5'd0);
		send_word(MODE_INS_AT, 32'h1234_5678, 5'd0);
		send_word(MODE_INS_AT, 32'h1234_5678, 5'd2);
		// Build a short list through each insert flavor, value extremes included.
		send_word(MODE_INS_AT, 32'h0, 5'd1);
		send_word(MODE_INS_HEAD, 32'hFFFF_FFFF, 5'd31);
		send_word(MODE_INS_TAIL, 32'hA5A5_A5A5, 5'd0);
		send_word(MODE_INS_AT, 32'h5A5A_5A5A, 5'd2);
		send_word(MODE_INS_AT, 32'h8000_0001, 5'd5);
		// Reads at each end, past the end and at position zero and the top position.
		send_word(MODE_READ_AT, 32'hFFFF_FFFF, 5'd1);
		send_word(MODE_READ_AT, 32'h0, 5'd5);
		send_word(MODE_READ_AT, 32'h0, 5'd6);
		send_word(MODE_READ_AT, 32'h0, 5'd0);
		send_word(MODE_READ_AT, 32'h0, 5'd31);
		// Unused mode, then deletes out of range, in the middle and at each end, and a read.
		send_word(MODE_UNUSED, 32'hFFFF_FFFF, 5'd31);
		send_word(MODE_DEL_AT, 32'h0, 5'd6);
		send_word(MODE_DEL_AT, 32'h0, 5'd3);
		send_word(MODE_DEL_HEAD, 32'h0, 5'd0);
		send_word(MODE_DEL_TAIL, 32'h0, 5'd0);
		send_word(MODE_READ_AT, 32'h0, 5'd2);

		// Random phases: each leans toward growing, shrinking or neither so the list swings between empty and full.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			span = $urandom_range(16, 64);
			trend = trend_t'($urandom_range(0, 2));
			send_calm = ($urandom_range(0, 3) == 0);
			for (i = 0; i < span && sent < RANDOM_WORDS; i++) begin
				mode = pick_mode(trend);
				case ($urandom_range(0, 19))
					0: value = 32'h0;
					1: value = 32'hFFFF_FFFF;
					default: value = $urandom;
				endcase
				if ($urandom_range(0, 4) != 0)
					pos = 5'($urandom_range(0, sb.occupancy + 1));
				else
					pos = 5'($urandom_range(0, 31));
				send_word(mode, value, pos);
				if (mode != MODE_UNUSED)
					sent++;
			end
		end
		req_ch.valid <= 1'b0;

		// Drain: let the monitor note the last request, wait for every owed
		// response, then a DRAIN_CYCLES wait for strays.
		@(posedge clk);
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
